FILE: hdl/frr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame reorder repair buffer package
// Shared types and constants for the reorder buffer and its backlog cells.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int MAX_BACKLOG = 32;
    localparam int MAX_MISSED  = 32;
    localparam int TAG_BITS    = 16;
    localparam int FRAME_BITS  = 32;
    localparam int OUT_CAP     = 34;
    localparam int BL_CW       = $clog2(MAX_BACKLOG + 1);
    localparam int MISS_CW     = $clog2(MAX_MISSED + 1);
    localparam int RES_AW      = $clog2(OUT_CAP + 1);
    localparam int RES_DEPTH   = 1 << RES_AW;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_TIMER = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_DROP    = 2'd1,
        KIND_RESEND  = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_RESTART  = 2'd1,
        CAUSE_OVERFLOW = 2'd2
    } t_cause;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [FRAME_BITS-1:0] frame;
    } t_held;

    typedef struct packed {
        t_kind kind;
        t_held held;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_SHL  = 2'd1,
        CELL_INS  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     ins_front;
    } t_cell_ctrl;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_DRAIN  = 9'b000000100,
        S_FLUSH  = 9'b000001000,
        S_LIST   = 9'b000010000,
        S_LROT   = 9'b000100000,
        S_FIN    = 9'b001000000,
        S_RD     = 9'b010000000,
        S_SHOW   = 9'b100000000
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/frame_reorder_repair_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame reorder repair buffer
// Restores frame order, holds early frames in a sorted cell chain and lists
// missing frames for resend.
// ----------------------------------------------------------------------------
// The block takes one word at a time and answers it with one or more result
// words, the final one marked by tlast. An item is taken, then decided, then
// each drained or dropped frame is handled in turn, and the item is closed; a
// timer item also emits its resend requests and turns the backlog chain once
// round before leaving its two loops. Each result word is then read from the
// result memory and shown.
module frame_reorder_repair_buffer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // frame_number, payload_tag
    input  wire logic [2:0]  s_axis_tuser,  // opcode, resent
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // out_frame, out_tag
    output logic [4:0]       m_axis_tuser,  // kind, repair_active, reset_cause
    output logic             m_axis_tlast
);

    localparam int NB = frr_pkg::MAX_BACKLOG;
    localparam int FB = frr_pkg::FRAME_BITS;

    frr_pkg::t_state r_state, n_state;
    logic            r_running, n_running;
    logic            r_repairing, n_repairing;
    logic [FB-1:0]   r_ld, n_ld;
    frr_pkg::t_held  r_fw, n_fw;
    logic [frr_pkg::BL_CW-1:0] r_count, n_count;
    frr_pkg::t_held  r_h, n_h;
    logic [1:0]      r_op, n_op;
    logic            r_resent, n_resent;
    frr_pkg::t_cause r_cause, n_cause;
    logic            r_fl_fw, n_fl_fw;
    logic            r_fl_tail, n_fl_tail;
    logic [FB-1:0]   r_cur, n_cur;
    logic [FB-1:0]   r_end, n_end;
    logic [frr_pkg::MISS_CW-1:0] r_missed, n_missed;
    logic [frr_pkg::BL_CW-1:0]   r_j, n_j;
    logic [frr_pkg::RES_AW-1:0]  r_nres, n_nres;
    logic [frr_pkg::RES_AW-1:0]  r_rd_ptr, n_rd_ptr;
    frr_pkg::t_result r_rd_data;
    frr_pkg::t_result r_res_mem [frr_pkg::RES_DEPTH];

    logic            e_valid;
    frr_pkg::t_kind  e_kind;
    frr_pkg::t_held  e_held;
    frr_pkg::t_cell_ctrl w_ctrl;
    frr_pkg::t_held  w_ins;
    frr_pkg::t_held  w_cell [NB];
    logic [NB-1:0]   w_gt, w_eq, w_vld;

    logic [FB-1:0]   w_d_ld, w_d_fw, w_d_list;
    logic            w_le0, w_is1, w_over, w_fw_eq, w_fw_lt, w_any_eq;
    logic            w_last;

    for (genvar gi = 0; gi < NB; gi++) begin : g_cell
        frr_pkg::t_held w_left;
        logic           w_gtp;
        if (gi == 0) begin : g_first
            assign w_left = w_ins;
            assign w_gtp  = 1'b0;
        end else begin : g_next
            assign w_left = w_cell[gi-1];
            assign w_gtp  = w_gt[gi-1];
        end
        assign w_vld[gi] = (frr_pkg::BL_CW'(gi) < r_count);
        frr_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_valid   (w_vld[gi]),
            .i_ins     (w_ins),
            .i_left    (w_left),
            .i_right   (w_cell[(gi + 1) % NB]),
            .i_gt_prev (w_gtp),
            .o_held    (w_cell[gi]),
            .o_gt      (w_gt[gi]),
            .o_eq      (w_eq[gi])
        );
    end

    assign w_d_ld   = r_h.frame - r_ld;
    assign w_d_fw   = r_h.frame - r_fw.frame;
    assign w_d_list = r_end - r_cur;
    assign w_le0    = w_d_ld[FB-1] || (w_d_ld == '0);
    assign w_is1    = (w_d_ld == FB'(1));
    assign w_over   = !w_d_ld[FB-1] && (w_d_ld > FB'(NB));
    assign w_fw_eq  = (w_d_fw == '0);
    assign w_fw_lt  = w_d_fw[FB-1];
    assign w_any_eq = |w_eq;
    assign w_last   = ((r_rd_ptr + frr_pkg::RES_AW'(1)) == r_nres);

    assign s_axis_tready = (r_state == frr_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == frr_pkg::S_SHOW);
    assign m_axis_tdata  = {r_rd_data.held.tag, r_rd_data.held.frame};
    assign m_axis_tuser  = {r_cause, r_repairing, r_rd_data.kind};
    assign m_axis_tlast  = w_last;

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_repairing = r_repairing;
        n_ld        = r_ld;
        n_fw        = r_fw;
        n_count     = r_count;
        n_h         = r_h;
        n_op        = r_op;
        n_resent    = r_resent;
        n_cause     = r_cause;
        n_fl_fw     = r_fl_fw;
        n_fl_tail   = r_fl_tail;
        n_cur       = r_cur;
        n_end       = r_end;
        n_missed    = r_missed;
        n_j         = r_j;
        n_nres      = r_nres;
        n_rd_ptr    = r_rd_ptr;
        e_valid     = 1'b0;
        e_kind      = frr_pkg::KIND_NONE;
        e_held      = r_h;
        w_ctrl      = '{op: frr_pkg::CELL_HOLD, ins_front: 1'b0};
        w_ins       = r_h;

        unique case (r_state)
            frr_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_h.frame = s_axis_tdata[FB-1:0];
                    n_h.tag   = s_axis_tdata[FB +: frr_pkg::TAG_BITS];
                    n_op      = s_axis_tuser[1:0];
                    n_resent  = s_axis_tuser[2];
                    n_nres    = '0;
                    n_cause   = frr_pkg::CAUSE_NONE;
                    n_state   = frr_pkg::S_DECIDE;
                end
            end
            frr_pkg::S_DECIDE: begin
                n_state = frr_pkg::S_FIN;
                unique case (r_op)
                    frr_pkg::OP_FRAME: begin
                        if (!r_running) begin
                            n_ld      = r_h.frame;
                            n_running = 1'b1;
                            e_valid   = 1'b1;
                            e_kind    = frr_pkg::KIND_DELIVER;
                        end else if (!r_repairing) begin
                            if (w_is1) begin
                                n_ld    = r_ld + FB'(1);
                                e_valid = 1'b1;
                                e_kind  = frr_pkg::KIND_DELIVER;
                            end else if (w_le0) begin
                                e_valid = 1'b1;
                                e_kind  = frr_pkg::KIND_DROP;
                                if (!r_resent) begin
                                    n_running = 1'b0;
                                    n_cause   = frr_pkg::CAUSE_RESTART;
                                end
                            end else begin
                                n_fw        = r_h;
                                n_count     = '0;
                                n_repairing = 1'b1;
                            end
                        end else begin
                            if (w_le0 && !r_resent) begin
                                n_cause   = frr_pkg::CAUSE_RESTART;
                                n_fl_fw   = 1'b1;
                                n_fl_tail = 1'b1;
                                n_state   = frr_pkg::S_FLUSH;
                            end else if (w_le0) begin
                                e_valid = 1'b1;
                                e_kind  = frr_pkg::KIND_DROP;
                            end else if (w_over) begin
                                n_cause   = frr_pkg::CAUSE_OVERFLOW;
                                n_fl_fw   = 1'b1;
                                n_fl_tail = 1'b1;
                                n_state   = frr_pkg::S_FLUSH;
                            end else if (w_is1) begin
                                n_ld    = r_ld + FB'(1);
                                e_valid = 1'b1;
                                e_kind  = frr_pkg::KIND_DELIVER;
                                n_state = frr_pkg::S_DRAIN;
                            end else if (w_fw_eq) begin
                                e_valid = 1'b1;
                                e_kind  = frr_pkg::KIND_DROP;
                            end else if (r_count >= frr_pkg::BL_CW'(NB)) begin
                                if (w_any_eq) begin
                                    e_valid = 1'b1;
                                    e_kind  = frr_pkg::KIND_DROP;
                                end else begin
                                    n_cause   = frr_pkg::CAUSE_OVERFLOW;
                                    n_fl_fw   = 1'b1;
                                    n_fl_tail = 1'b1;
                                    n_state   = frr_pkg::S_FLUSH;
                                end
                            end else if (w_fw_lt) begin
                                w_ctrl  = '{op: frr_pkg::CELL_INS, ins_front: 1'b1};
                                w_ins   = r_fw;
                                n_fw    = r_h;
                                n_count = r_count + frr_pkg::BL_CW'(1);
                            end else if (w_any_eq) begin
                                e_valid = 1'b1;
                                e_kind  = frr_pkg::KIND_DROP;
                            end else begin
                                w_ctrl  = '{op: frr_pkg::CELL_INS, ins_front: 1'b0};
                                n_count = r_count + frr_pkg::BL_CW'(1);
                            end
                        end
                    end
                    frr_pkg::OP_TIMER: begin
                        if (r_repairing) begin
                            n_cur    = r_ld + FB'(1);
                            n_end    = r_fw.frame;
                            n_missed = '0;
                            n_j      = '0;
                            n_state  = frr_pkg::S_LIST;
                        end
                    end
                    frr_pkg::OP_STOP: begin
                        n_ld = '0;
                        if (r_repairing) begin
                            n_fl_fw   = 1'b1;
                            n_fl_tail = 1'b0;
                            n_state   = frr_pkg::S_FLUSH;
                        end else begin
                            n_running = 1'b0;
                        end
                    end
                    default: begin
                        n_state = frr_pkg::S_FIN;
                    end
                endcase
            end
            frr_pkg::S_FLUSH: begin
                if (r_fl_fw) begin
                    e_valid = 1'b1;
                    e_kind  = frr_pkg::KIND_DROP;
                    e_held  = r_fw;
                    n_fl_fw = 1'b0;
                end else if (r_count != '0) begin
                    e_valid = 1'b1;
                    e_kind  = frr_pkg::KIND_DROP;
                    e_held  = w_cell[0];
                    w_ctrl  = '{op: frr_pkg::CELL_SHL, ins_front: 1'b0};
                    n_count = r_count - frr_pkg::BL_CW'(1);
                end else if (r_fl_tail) begin
                    e_valid   = 1'b1;
                    e_kind    = frr_pkg::KIND_DROP;
                    n_fl_tail = 1'b0;
                end else begin
                    n_running   = 1'b0;
                    n_repairing = 1'b0;
                    n_state     = frr_pkg::S_FIN;
                end
            end
            frr_pkg::S_DRAIN: begin
                if (r_fw.frame == r_ld + FB'(1)) begin
                    n_ld    = r_ld + FB'(1);
                    e_valid = 1'b1;
                    e_kind  = frr_pkg::KIND_DELIVER;
                    e_held  = r_fw;
                    if (r_count == '0) begin
                        n_repairing = 1'b0;
                        n_state     = frr_pkg::S_FIN;
                    end else begin
                        n_fw    = w_cell[0];
                        w_ctrl  = '{op: frr_pkg::CELL_SHL, ins_front: 1'b0};
                        n_count = r_count - frr_pkg::BL_CW'(1);
                    end
                end else begin
                    n_state = frr_pkg::S_FIN;
                end
            end
            frr_pkg::S_LIST: begin
                if ((r_missed < frr_pkg::MISS_CW'(frr_pkg::MAX_MISSED)) &&
                    !w_d_list[FB-1] && (w_d_list != '0)) begin
                    e_valid      = 1'b1;
                    e_kind       = frr_pkg::KIND_RESEND;
                    e_held.frame = r_cur;
                    e_held.tag   = '0;
                    n_cur        = r_cur + FB'(1);
                    n_missed     = r_missed + frr_pkg::MISS_CW'(1);
                end else if ((r_missed < frr_pkg::MISS_CW'(frr_pkg::MAX_MISSED)) &&
                             (r_j < r_count)) begin
                    n_cur  = r_end + FB'(1);
                    n_end  = w_cell[0].frame;
                    w_ctrl = '{op: frr_pkg::CELL_SHL, ins_front: 1'b0};
                    n_j    = r_j + frr_pkg::BL_CW'(1);
                end else begin
                    n_state = frr_pkg::S_LROT;
                end
            end
            frr_pkg::S_LROT: begin
                if (r_j != frr_pkg::BL_CW'(NB)) begin
                    w_ctrl = '{op: frr_pkg::CELL_SHL, ins_front: 1'b0};
                    n_j    = r_j + frr_pkg::BL_CW'(1);
                end else begin
                    n_state = frr_pkg::S_FIN;
                end
            end
            frr_pkg::S_FIN: begin
                if (r_nres == '0) begin
                    e_valid = 1'b1;
                    e_kind  = frr_pkg::KIND_NONE;
                    e_held  = '0;
                end
                n_rd_ptr = '0;
                n_state  = frr_pkg::S_RD;
            end
            frr_pkg::S_RD: begin
                n_state = frr_pkg::S_SHOW;
            end
            frr_pkg::S_SHOW: begin
                if (m_axis_tready) begin
                    if (w_last) begin
                        n_state = frr_pkg::S_IDLE;
                    end else begin
                        n_rd_ptr = r_rd_ptr + frr_pkg::RES_AW'(1);
                        n_state  = frr_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = frr_pkg::S_IDLE;
            end
        endcase

        if (e_valid && (r_nres < frr_pkg::RES_AW'(frr_pkg::OUT_CAP))) begin
            n_nres = r_nres + frr_pkg::RES_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid && (r_nres < frr_pkg::RES_AW'(frr_pkg::OUT_CAP))) begin
            r_res_mem[r_nres] <= '{kind: e_kind, held: e_held};
        end
        if (r_state == frr_pkg::S_RD) begin
            r_rd_data <= r_res_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw     <= n_fw;
        r_h      <= n_h;
        r_op     <= n_op;
        r_resent <= n_resent;
        r_cur    <= n_cur;
        r_end    <= n_end;
        if (!i_rst_n) begin
            r_state     <= frr_pkg::S_IDLE;
            r_running   <= 1'b0;
            r_repairing <= 1'b0;
            r_ld        <= '0;
            r_count     <= '0;
            r_cause     <= frr_pkg::CAUSE_NONE;
            r_fl_fw     <= 1'b0;
            r_fl_tail   <= 1'b0;
            r_missed    <= '0;
            r_j         <= '0;
            r_nres      <= '0;
            r_rd_ptr    <= '0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_repairing <= n_repairing;
            r_ld        <= n_ld;
            r_count     <= n_count;
            r_cause     <= n_cause;
            r_fl_fw     <= n_fl_fw;
            r_fl_tail   <= n_fl_tail;
            r_missed    <= n_missed;
            r_j         <= n_j;
            r_nres      <= n_nres;
            r_rd_ptr    <= n_rd_ptr;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= frr_pkg::BL_CW'(NB))
        else $error("backlog count beyond capacity");

    a_held_needs_repair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_repairing && r_running))
        else $error("frames held outside repair");

    a_show_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_rd_ptr < r_nres))
        else $error("result word shown beyond written results");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is shown");

endmodule
`default_nettype wire

FILE: hdl/frr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlog cell
// Holds one waiting frame; shifts, takes an inserted word or holds.
// ----------------------------------------------------------------------------
module frr_cell (
    input  wire logic              i_clk,
    input  wire frr_pkg::t_cell_ctrl i_ctrl,
    input  wire logic              i_valid,
    input  wire frr_pkg::t_held    i_ins,
    input  wire frr_pkg::t_held    i_left,
    input  wire frr_pkg::t_held    i_right,
    input  wire logic              i_gt_prev,
    output frr_pkg::t_held         o_held,
    output logic                   o_gt,
    output logic                   o_eq
);

    frr_pkg::t_held r_held;
    frr_pkg::t_held n_held;
    logic [frr_pkg::FRAME_BITS-1:0] w_diff;

    assign w_diff = i_ins.frame - r_held.frame;
    assign o_gt   = !i_valid || w_diff[frr_pkg::FRAME_BITS-1] || i_ctrl.ins_front;
    assign o_eq   = i_valid && (i_ins.frame == r_held.frame);
    assign o_held = r_held;

    always_comb begin
        n_held = r_held;
        unique case (i_ctrl.op)
            frr_pkg::CELL_SHL: begin
                n_held = i_right;
            end
            frr_pkg::CELL_INS: begin
                if (i_gt_prev) begin
                    n_held = i_left;
                end else if (o_gt) begin
                    n_held = i_ins;
                end
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule
`default_nettype wire

FILE: test/frame_reorder_repair_buffer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame reorder repair buffer testbench
// Drives the buffer with a table of directed words and then with random
// frame sequences, and checks every result word against a behavioural copy
// of the reorder, repair and resend logic kept inside this testbench.
// ----------------------------------------------------------------------------
module frame_reorder_repair_buffer_unit_test;
    import frr_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [31:0] frame;
        logic [15:0] tag;
        logic        rep;
        t_cause      cause;
        logic        last;
    } t_out_word;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] frame;
        logic        resent;
        logic [15:0] tag;
        bit          chk;
        t_kind       ekind;
        logic [31:0] eframe;
        t_cause      ecause;
    } t_plan_row;

    localparam int N_PLAN = 23;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF = 400;
    localparam logic [1:0] OP_SPARE = 2'd3;

    t_plan_row plan [N_PLAN] = '{
        '{OP_FRAME, 32'd100, 1'b0, 16'h0000, 1, KIND_DELIVER, 32'd100, CAUSE_NONE},
        '{OP_FRAME, 32'd101, 1'b0, 16'hFFFF, 1, KIND_DELIVER, 32'd101, CAUSE_NONE},
        '{OP_FRAME, 32'd104, 1'b0, 16'h1234, 1, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_FRAME, 32'd103, 1'b0, 16'h5678, 1, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_FRAME, 32'd103, 1'b1, 16'h9ABC, 1, KIND_DROP, 32'd103, CAUSE_NONE},
        '{OP_TIMER, 32'd0, 1'b0, 16'h0000, 1, KIND_RESEND, 32'd102, CAUSE_NONE},
        '{OP_FRAME, 32'd102, 1'b1, 16'hAAAA, 1, KIND_DELIVER, 32'd102, CAUSE_NONE},
        '{OP_FRAME, 32'd50, 1'b1, 16'h5555, 1, KIND_DROP, 32'd50, CAUSE_NONE},
        '{OP_FRAME, 32'd50, 1'b0, 16'h5555, 1, KIND_DROP, 32'd50, CAUSE_RESTART},
        '{OP_FRAME, 32'hFFFFFFFF, 1'b0, 16'hFFFF, 1, KIND_DELIVER, 32'hFFFFFFFF,
          CAUSE_NONE},
        '{OP_FRAME, 32'd0, 1'b0, 16'h0001, 1, KIND_DELIVER, 32'd0, CAUSE_NONE},
        '{OP_FRAME, 32'd40, 1'b0, 16'h0040, 1, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_FRAME, 32'd2, 1'b1, 16'h0002, 0, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_TIMER, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 0, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_FRAME, 32'd100, 1'b0, 16'h0100, 1, KIND_DROP, 32'd2, CAUSE_OVERFLOW},
        '{OP_FRAME, 32'd7, 1'b0, 16'h0007, 1, KIND_DELIVER, 32'd7, CAUSE_NONE},
        '{OP_FRAME, 32'd9, 1'b0, 16'h0009, 1, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_TIMER, 32'd0, 1'b0, 16'h0000, 1, KIND_RESEND, 32'd8, CAUSE_NONE},
        '{OP_STOP, 32'd0, 1'b0, 16'h0000, 1, KIND_DROP, 32'd9, CAUSE_NONE},
        '{OP_SPARE, 32'hDEADBEEF, 1'b1, 16'hBEEF, 1, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_TIMER, 32'd0, 1'b0, 16'h0000, 1, KIND_NONE, 32'd0, CAUSE_NONE},
        '{OP_FRAME, 32'h7FFFFFFF, 1'b0, 16'h8000, 1, KIND_DELIVER, 32'h7FFFFFFF,
          CAUSE_NONE},
        '{OP_FRAME, 32'h80000000, 1'b0, 16'h7FFF, 1, KIND_DELIVER, 32'h80000000,
          CAUSE_NONE}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // frame_number, payload_tag
    logic [2:0]  s_axis_tuser;   // opcode, resent
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_frame, out_tag
    logic [4:0]  m_axis_tuser;   // kind, repair_active, reset_cause
    logic        m_axis_tlast;

    frame_reorder_repair_buffer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Behavioural copy of the buffer state.
    bit          is_running;
    bit          is_repairing;
    logic [31:0] last_del;
    t_held       first_wait;
    t_held       held_list [MAX_BACKLOG];
    int          held_cnt;
    t_out_word   item_words [$];
    t_out_word   pending_words [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off_req;
    int  errors;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int wrap_diff(logic [31:0] a, logic [31:0] b);
        return signed'(a - b);
    endfunction

    function automatic void add_word(t_kind kind, logic [31:0] frame, logic [15:0] tag);
        t_out_word w;
        if (item_words.size() < OUT_CAP) begin
            w.kind = kind;
            w.frame = frame;
            w.tag = tag;
            w.rep = 1'b0;
            w.cause = CAUSE_NONE;
            w.last = 1'b0;
            item_words = {item_words, w};
        end
    endfunction

    function automatic void drop_all_held();
        if (is_repairing) begin
            add_word(KIND_DROP, first_wait.frame, first_wait.tag);
            for (int i = 0; i < held_cnt; i++) begin
                add_word(KIND_DROP, held_list[i].frame, held_list[i].tag);
            end
        end
        held_cnt = 0;
        is_running = 0;
        is_repairing = 0;
    endfunction

    function automatic void list_missing(logic [31:0] first, logic [31:0] stop, ref int count);
        logic [31:0] n;
        n = stop - first;
        if (wrap_diff(stop, first) <= 0) begin
            return;
        end
        for (logic [31:0] i = 0; i < n && count < MAX_MISSED; i++) begin
            add_word(KIND_RESEND, first + i, 16'h0000);
            count++;
        end
    endfunction

    function automatic void hold_at(int pos, t_held h);
        for (int i = held_cnt; i > pos; i--) begin
            held_list[i] = held_list[i - 1];
        end
        held_list[pos] = h;
        held_cnt++;
    endfunction

    function automatic t_cause repair_frame(t_held h, logic resent);
        int  d;
        bit  dup;
        d = wrap_diff(h.frame, last_del);
        if (d < 1) begin
            if (!resent) begin
                drop_all_held();
                add_word(KIND_DROP, h.frame, h.tag);
                return CAUSE_RESTART;
            end
            add_word(KIND_DROP, h.frame, h.tag);
            return CAUSE_NONE;
        end
        if (d > MAX_BACKLOG) begin
            drop_all_held();
            add_word(KIND_DROP, h.frame, h.tag);
            return CAUSE_OVERFLOW;
        end
        if (d == 1) begin
            last_del++;
            add_word(KIND_DELIVER, h.frame, h.tag);
            while (first_wait.frame == last_del + 1) begin
                last_del++;
                add_word(KIND_DELIVER, first_wait.frame, first_wait.tag);
                if (held_cnt == 0) begin
                    is_repairing = 0;
                    break;
                end
                first_wait = held_list[0];
                held_cnt--;
                for (int i = 0; i < held_cnt; i++) begin
                    held_list[i] = held_list[i + 1];
                end
            end
            return CAUSE_NONE;
        end
        d = wrap_diff(h.frame, first_wait.frame);
        if (d == 0) begin
            add_word(KIND_DROP, h.frame, h.tag);
            return CAUSE_NONE;
        end
        if (held_cnt >= MAX_BACKLOG) begin
            dup = 0;
            for (int i = 0; i < MAX_BACKLOG; i++) begin
                if (held_list[i].frame == h.frame) dup = 1;
            end
            if (!dup) begin
                drop_all_held();
                add_word(KIND_DROP, h.frame, h.tag);
                return CAUSE_OVERFLOW;
            end
            add_word(KIND_DROP, h.frame, h.tag);
            return CAUSE_NONE;
        end
        if (d < 0) begin
            hold_at(0, first_wait);
            first_wait = h;
            return CAUSE_NONE;
        end
        for (int i = 0; i < held_cnt; i++) begin
            d = wrap_diff(h.frame, held_list[i].frame);
            if (d > 0) continue;
            if (d == 0) add_word(KIND_DROP, h.frame, h.tag);
            else hold_at(i, h);
            return CAUSE_NONE;
        end
        hold_at(held_cnt, h);
        return CAUSE_NONE;
    endfunction

    // Works out the result words of one accepted word into item_words.
    function automatic void predict_reorder(logic [1:0] op, logic [31:0] frame,
                                            logic resent, logic [15:0] tag);
        t_held       h;
        t_cause      cause;
        int          count;
        logic [31:0] stop;
        logic [31:0] first;
        int          d;
        h.frame = frame;
        h.tag = tag;
        cause = CAUSE_NONE;
        item_words.delete();
        if (op == OP_FRAME) begin
            if (!is_running) begin
                last_del = frame;
                is_running = 1;
                add_word(KIND_DELIVER, frame, tag);
            end else if (is_repairing) begin
                cause = repair_frame(h, resent);
            end else begin
                d = wrap_diff(frame, last_del);
                if (d == 1) begin
                    last_del++;
                    add_word(KIND_DELIVER, frame, tag);
                end else if (d < 1) begin
                    add_word(KIND_DROP, frame, tag);
                    if (!resent) begin
                        drop_all_held();
                        cause = CAUSE_RESTART;
                    end
                end else begin
                    first_wait = h;
                    held_cnt = 0;
                    is_repairing = 1;
                end
            end
        end else if (op == OP_TIMER) begin
            if (is_repairing) begin
                count = 0;
                stop = first_wait.frame;
                list_missing(last_del + 1, stop, count);
                for (int j = 0; count < MAX_MISSED && j < held_cnt; j++) begin
                    first = stop + 1;
                    stop = held_list[j].frame;
                    list_missing(first, stop, count);
                end
            end
        end else if (op == OP_STOP) begin
            drop_all_held();
            last_del = '0;
        end
        if (item_words.size() == 0) add_word(KIND_NONE, 32'd0, 16'h0000);
        foreach (item_words[k]) begin
            item_words[k].rep = is_repairing;
            item_words[k].cause = cause;
            item_words[k].last = (k == item_words.size() - 1);
        end
    endfunction

    task automatic send_word(logic [1:0] op, logic [31:0] frame, logic resent,
                             logic [15:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, frame};
        s_axis_tuser  <= {resent, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_reorder(op, frame, resent, tag);
        pending_words = {pending_words, item_words};
    endtask

    task automatic send_random(int n);
        logic [1:0]  op;
        logic [31:0] frame;
        int          pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            op = OP_FRAME;
            if (pick < 55) frame = last_del + $urandom_range(1, 12);
            else if (pick < 65) frame = last_del - $urandom_range(0, 5);
            else if (pick < 72) frame = last_del + $urandom_range(28, 40);
            else if (pick < 78) frame = $urandom;
            else if (pick < 92) begin
                op = OP_TIMER;
                frame = $urandom;
            end else if (pick < 96) begin
                op = OP_STOP;
                frame = $urandom;
            end else begin
                op = OP_SPARE;
                frame = $urandom;
            end
            send_word(op, frame, ($urandom_range(2) == 0), 16'($urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, and the checks.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: expected no word, actual %h %h", $realtime,
                             m_axis_tuser, m_axis_tdata);
                    errors++;
                end else begin
                    t_out_word w;
                    w = pending_words.pop_front();
                    if ({w.cause, w.rep, w.kind} !== m_axis_tuser
                        || {w.tag, w.frame} !== m_axis_tdata
                        || w.last !== m_axis_tlast) begin
                        $display("%0t: expected kind %0d frame %h tag %h rep %0d cause %0d last %0d",
                                 $realtime, w.kind, w.frame, w.tag, w.rep, w.cause, w.last);
                        $display("%0t: actual   kind %0d frame %h tag %h rep %0d cause %0d last %0d",
                                 $realtime, m_axis_tuser[1:0], m_axis_tdata[31:0],
                                 m_axis_tdata[47:32], m_axis_tuser[2], m_axis_tuser[4:3],
                                 m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_off_req && hold_left == 0) begin
                hold_left = HOLD_OFF;
                hold_off_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        hold_off_req  = 1'b0;
        errors        = 0;
        quiet_cycles  = 0;
        send_idle_pct = 10;
        recv_idle_pct = 88;
        is_running    = 0;
        is_repairing  = 0;
        last_del      = '0;
        held_cnt      = 0;
        first_wait    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_PLAN; r++) begin
            send_word(plan[r].op, plan[r].frame, plan[r].resent, plan[r].tag);
            if (plan[r].chk && (item_words[0].kind !== plan[r].ekind
                || item_words[0].frame !== plan[r].eframe
                || item_words[0].cause !== plan[r].ecause)) begin
                $display("%0t: row %0d expected kind %0d frame %h cause %0d", $realtime, r,
                         plan[r].ekind, plan[r].eframe, plan[r].ecause);
                $display("%0t: row %0d actual   kind %0d frame %h cause %0d", $realtime, r,
                         item_words[0].kind, item_words[0].frame, item_words[0].cause);
                errors++;
            end
        end
        send_random(35);
        send_idle_pct = 88;
        recv_idle_pct = 10;
        send_random(36);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
        send_random(36);
        s_axis_tvalid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
